@@ hw/rtl/bsde_pkg.sv @@
// ----------------------------------------------------------------------------
// bsde_pkg
// shared types, codes and fixed-point helpers of the b-spline evaluator
// ----------------------------------------------------------------------------
package bsde_pkg;

    localparam int DEF_MAX_ORDER   = 10;
    localparam int DEF_MAX_CONTROL = 1024;
    localparam int QUEUE_DEPTH     = 2;

    // item opcodes
    localparam logic [1:0] OP_KNOT = 2'd0;
    localparam logic [1:0] OP_COEF = 2'd1;
    localparam logic [1:0] OP_EVAL = 2'd2;

    // configuration register indexes
    localparam logic REG_ORDER = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [10:0]        table_index;
        logic signed [31:0] entry_value;
        logic signed [31:0] abscissa;
    } bsde_item_t;

    // saturate to q16.16, bit 32 is the clip flag
    function automatic logic [32:0] sat33(input logic signed [32:0] v);
        logic [32:0] r;
        if (!v[32] && v[31]) begin
            r = {1'b1, Q_MAX};
        end else if (v[32] && !v[31]) begin
            r = {1'b1, Q_MIN};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? 32'(-v) : 32'(v);
        return r;
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        logic [32:0] r;
        r = v[32] ? 33'(-v) : 33'(v);
        return r;
    endfunction

endpackage

@@ hw/rtl/bsde_ram.sv @@
// ----------------------------------------------------------------------------
// bsde_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bsde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/bsde_div.sv @@
// ----------------------------------------------------------------------------
// bsde_div
// restoring divider, one quotient bit a cycle, signed q16.16 saturated result
// ----------------------------------------------------------------------------
module bsde_div
    import bsde_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [63:0]        dividend,
    input  logic [32:0]        divisor,
    input  logic               neg,
    output logic               done,
    output logic signed [31:0] quot,
    output logic               clip
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] rem_reg;
    logic [63:0] dsh_reg;
    logic [31:0] q_reg;
    logic        neg_reg;
    logic        zero_reg;
    logic        ovf_reg;
    logic        take;

    assign take = (rem_reg >= dsh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end else if (busy_reg) begin
                if (cnt_reg != '0) begin
                    cnt_reg <= cnt_reg - 6'd1;
                end else begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            zero_reg <= (divisor == '0);
            ovf_reg  <= ({1'b0, dividend} >= {divisor, 32'b0});
            neg_reg  <= neg;
            rem_reg  <= dividend;
            dsh_reg  <= {divisor, 31'b0};
            q_reg    <= '0;
        end else if (busy_reg && cnt_reg != '0) begin
            if (take) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[30:0], take};
            dsh_reg <= {1'b0, dsh_reg[63:1]};
        end
    end

    always_comb begin
        if (zero_reg) begin
            quot = '0;
            clip = 1'b0;
        end else if (ovf_reg) begin
            quot = neg_reg ? Q_MIN : Q_MAX;
            clip = 1'b1;
        end else if (neg_reg) begin
            if (q_reg > 32'h8000_0000) begin
                quot = Q_MIN;
                clip = 1'b1;
            end else begin
                quot = $signed(32'(-q_reg));
                clip = 1'b0;
            end
        end else begin
            if (q_reg[31]) begin
                quot = Q_MAX;
                clip = 1'b1;
            end else begin
                quot = $signed(q_reg);
                clip = 1'b0;
            end
        end
    end

    assign done = done_reg;

endmodule

@@ hw/rtl/bsde_front.sv @@
// ----------------------------------------------------------------------------
// bsde_front
// input side: takes items, drops unknown opcodes, queues the rest
// ----------------------------------------------------------------------------
module bsde_front
    import bsde_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  bsde_item_t in_item,
    output logic       q_valid,
    output bsde_item_t q_item,
    input  logic       q_pop
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    bsde_item_t     mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [NW-1:0]  count_reg;
    logic           push;
    logic           pop;
    logic           known;

    assign known    = in_item.opcode inside {OP_KNOT, OP_COEF, OP_EVAL};
    assign in_ready = (count_reg != NW'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready && known;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ hw/rtl/bsde_back.sv @@
// ----------------------------------------------------------------------------
// bsde_back
// execution side: table writes, span search, de boor recursion, dot product
// ----------------------------------------------------------------------------
module bsde_back
    import bsde_pkg::*;
#(
    parameter int MAX_ORDER   = DEF_MAX_ORDER,
    parameter int MAX_CONTROL = DEF_MAX_CONTROL
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  bsde_item_t         q_item,
    output logic               q_pop,
    input  logic [3:0]         spline_order,
    input  logic [10:0]        control_count,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_value,
    output logic               out_sat
);

    localparam int KNOT_DEPTH = MAX_CONTROL + MAX_ORDER;
    localparam int KNOT_AW    = $clog2(KNOT_DEPTH);
    localparam int COEF_AW    = $clog2(MAX_CONTROL);
    localparam int KW         = $clog2(KNOT_DEPTH + 1);
    localparam int JW         = $clog2(MAX_ORDER);
    localparam int CW         = JW + 1;
    localparam int ACC_W      = 56;
    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(Q_MAX);
    localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(Q_MIN);

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_RD_LO   = 5'd1;
    localparam logic [4:0] ST_CMP_LO  = 5'd2;
    localparam logic [4:0] ST_RD_HI   = 5'd3;
    localparam logic [4:0] ST_CMP_HI  = 5'd4;
    localparam logic [4:0] ST_SRCH    = 5'd5;
    localparam logic [4:0] ST_SCMP    = 5'd6;
    localparam logic [4:0] ST_RD_DR   = 5'd7;
    localparam logic [4:0] ST_RD_DL   = 5'd8;
    localparam logic [4:0] ST_GOT_DL  = 5'd9;
    localparam logic [4:0] ST_MUL1    = 5'd10;
    localparam logic [4:0] ST_DIV1    = 5'd11;
    localparam logic [4:0] ST_WAIT1   = 5'd12;
    localparam logic [4:0] ST_MUL2    = 5'd13;
    localparam logic [4:0] ST_DIV2    = 5'd14;
    localparam logic [4:0] ST_WAIT2   = 5'd15;
    localparam logic [4:0] ST_DOT_RD  = 5'd16;
    localparam logic [4:0] ST_DOT_MUL = 5'd17;
    localparam logic [4:0] ST_DOT_ACC = 5'd18;
    localparam logic [4:0] ST_DONE    = 5'd19;

    logic [4:0]               state_reg;
    logic signed [31:0]       x_reg;
    logic [KW-1:0]            k_reg, n_reg, lo_reg, hi_reg, mid_reg, l_reg;
    logic [CW-1:0]            j_reg, i_reg;
    logic signed [31:0]       dr_reg [MAX_ORDER];
    logic signed [31:0]       dl_reg [MAX_ORDER];
    logic signed [31:0]       b_reg  [MAX_ORDER];
    logic signed [31:0]       carry_reg, term1_reg, bi_reg;
    logic signed [32:0]       den_reg;
    logic [63:0]              prod_reg;
    logic                     prod_neg_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     flag_reg;
    logic                     out_valid_reg;
    logic signed [31:0]       out_value_reg;
    logic                     out_sat_reg;

    logic [JW-1:0]            ii, jj, jmi, jp1;
    logic [31:0]              k_c, n_c;
    logic [KW:0]              mid_sum;
    logic [KW-1:0]            knot_ra;
    logic [KW-1:0]            coef_ra;
    logic [31:0]              idx32;
    logic                     knot_we, coef_we;
    logic [31:0]              knot_rd_u, coef_rd_u;
    logic signed [31:0]       knot_rd, coef_rd;
    logic signed [31:0]       mul_a, mul_b;
    logic [63:0]              prod_c;
    logic signed [32:0]       den_c;
    logic [32:0]              dr_sat, dl_sat, sum_sat;
    logic signed [ACC_W-1:0]  pext, term_c;
    logic                     div_start, div_done, div_clip;
    logic signed [31:0]       div_q;
    logic                     load_out;

    assign ii  = i_reg[JW-1:0];
    assign jj  = j_reg[JW-1:0];
    assign jmi = JW'(j_reg - i_reg);
    assign jp1 = JW'(j_reg + 1'b1);

    // clamp order and count at evaluation start
    always_comb begin
        if (spline_order < 4'd2) begin
            k_c = 32'd2;
        end else if (32'(spline_order) > MAX_ORDER) begin
            k_c = MAX_ORDER;
        end else begin
            k_c = 32'(spline_order);
        end
        if (32'(control_count) < k_c) begin
            n_c = k_c;
        end else if (32'(control_count) > MAX_CONTROL) begin
            n_c = MAX_CONTROL;
        end else begin
            n_c = 32'(control_count);
        end
    end

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign idx32   = 32'(q_item.table_index);
    assign q_pop   = (state_reg == ST_IDLE) && q_valid;
    assign knot_we = q_pop && (q_item.opcode == OP_KNOT) && (idx32 < KNOT_DEPTH);
    assign coef_we = q_pop && (q_item.opcode == OP_COEF) && (idx32 < MAX_CONTROL);

    always_comb begin
        case (state_reg)
            ST_RD_LO: knot_ra = k_reg - 1'b1;
            ST_RD_HI: knot_ra = n_reg;
            ST_SRCH:  knot_ra = mid_sum[KW:1];
            ST_RD_DR: knot_ra = l_reg + KW'(j_reg) + 1'b1;
            ST_RD_DL: knot_ra = l_reg - KW'(j_reg);
            default:  knot_ra = '0;
        endcase
    end

    assign coef_ra = l_reg - (k_reg - 1'b1) + KW'(i_reg);

    bsde_ram #(.WIDTH(32), .DEPTH(KNOT_DEPTH)) u_knot_ram (
        .aclk  (aclk),
        .we    (knot_we),
        .waddr (idx32[KNOT_AW-1:0]),
        .wdata (q_item.entry_value),
        .raddr (knot_ra[KNOT_AW-1:0]),
        .rdata (knot_rd_u)
    );

    bsde_ram #(.WIDTH(32), .DEPTH(MAX_CONTROL)) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (idx32[COEF_AW-1:0]),
        .wdata (q_item.entry_value),
        .raddr (coef_ra[COEF_AW-1:0]),
        .rdata (coef_rd_u)
    );

    assign knot_rd = $signed(knot_rd_u);
    assign coef_rd = $signed(coef_rd_u);

    // one shared magnitude multiplier
    always_comb begin
        case (state_reg)
            ST_MUL1: begin
                mul_a = dr_reg[ii];
                mul_b = b_reg[ii];
            end
            ST_MUL2: begin
                mul_a = dl_reg[jmi];
                mul_b = bi_reg;
            end
            ST_DOT_MUL: begin
                mul_a = coef_rd;
                mul_b = b_reg[ii];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_c  = 64'(mag32(mul_a)) * 64'(mag32(mul_b));
    assign den_c   = 33'(dr_reg[ii]) + 33'(dl_reg[jmi]);
    assign dr_sat  = sat33(33'(knot_rd) - 33'(x_reg));
    assign dl_sat  = sat33(33'(x_reg) - 33'(knot_rd));
    assign sum_sat = sat33(33'(carry_reg) + 33'(term1_reg));
    assign pext    = $signed({{(ACC_W - 48){1'b0}}, prod_reg[63:16]});
    assign term_c  = prod_neg_reg ? -pext : pext;

    assign div_start = (state_reg == ST_DIV1) || (state_reg == ST_DIV2);

    bsde_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (mag33(den_reg)),
        .neg      (prod_neg_reg ^ den_reg[32]),
        .done     (div_done),
        .quot     (div_q),
        .clip     (div_clip)
    );

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            flag_reg      <= 1'b0;
        end else begin
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid && q_item.opcode == OP_EVAL) begin
                        x_reg    <= q_item.abscissa;
                        k_reg    <= KW'(k_c);
                        n_reg    <= KW'(n_c);
                        flag_reg <= 1'b0;
                        state_reg <= ST_RD_LO;
                    end
                end
                ST_RD_LO: state_reg <= ST_CMP_LO;
                ST_CMP_LO: begin
                    if (x_reg < knot_rd) begin
                        l_reg     <= k_reg - 1'b1;
                        b_reg[0]  <= Q_ONE;
                        j_reg     <= '0;
                        state_reg <= ST_RD_DR;
                    end else begin
                        state_reg <= ST_RD_HI;
                    end
                end
                ST_RD_HI: state_reg <= ST_CMP_HI;
                ST_CMP_HI: begin
                    if (x_reg >= knot_rd) begin
                        l_reg     <= n_reg - 1'b1;
                        b_reg[0]  <= Q_ONE;
                        j_reg     <= '0;
                        state_reg <= ST_RD_DR;
                    end else begin
                        lo_reg    <= k_reg - 1'b1;
                        hi_reg    <= n_reg;
                        state_reg <= ST_SRCH;
                    end
                end
                ST_SRCH: begin
                    if (hi_reg - lo_reg > KW'(1)) begin
                        mid_reg   <= mid_sum[KW:1];
                        state_reg <= ST_SCMP;
                    end else begin
                        l_reg     <= lo_reg;
                        b_reg[0]  <= Q_ONE;
                        j_reg     <= '0;
                        state_reg <= ST_RD_DR;
                    end
                end
                ST_SCMP: begin
                    if (x_reg < knot_rd) begin
                        hi_reg <= mid_reg;
                    end else begin
                        lo_reg <= mid_reg;
                    end
                    state_reg <= ST_SRCH;
                end
                ST_RD_DR: state_reg <= ST_RD_DL;
                ST_RD_DL: begin
                    dr_reg[jj] <= $signed(dr_sat[31:0]);
                    flag_reg   <= flag_reg | dr_sat[32];
                    state_reg  <= ST_GOT_DL;
                end
                ST_GOT_DL: begin
                    dl_reg[jj] <= $signed(dl_sat[31:0]);
                    flag_reg   <= flag_reg | dl_sat[32];
                    i_reg      <= '0;
                    carry_reg  <= '0;
                    state_reg  <= ST_MUL1;
                end
                ST_MUL1: begin
                    prod_reg     <= prod_c;
                    prod_neg_reg <= mul_a[31] ^ mul_b[31];
                    den_reg      <= den_c;
                    bi_reg       <= b_reg[ii];
                    state_reg    <= ST_DIV1;
                end
                ST_DIV1: state_reg <= ST_WAIT1;
                ST_WAIT1: begin
                    if (div_done) begin
                        term1_reg <= div_q;
                        flag_reg  <= flag_reg | div_clip;
                        state_reg <= ST_MUL2;
                    end
                end
                ST_MUL2: begin
                    prod_reg     <= prod_c;
                    prod_neg_reg <= mul_a[31] ^ mul_b[31];
                    state_reg    <= ST_DIV2;
                end
                ST_DIV2: state_reg <= ST_WAIT2;
                ST_WAIT2: begin
                    if (div_done) begin
                        b_reg[ii] <= $signed(sum_sat[31:0]);
                        flag_reg  <= flag_reg | sum_sat[32] | div_clip;
                        carry_reg <= div_q;
                        if (i_reg == j_reg) begin
                            b_reg[jp1] <= div_q;
                            if (32'(j_reg) + 32'd2 < 32'(k_reg)) begin
                                j_reg     <= j_reg + 1'b1;
                                state_reg <= ST_RD_DR;
                            end else begin
                                i_reg     <= '0;
                                acc_reg   <= '0;
                                state_reg <= ST_DOT_RD;
                            end
                        end else begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= ST_MUL1;
                        end
                    end
                end
                ST_DOT_RD: state_reg <= ST_DOT_MUL;
                ST_DOT_MUL: begin
                    prod_reg     <= prod_c;
                    prod_neg_reg <= mul_a[31] ^ mul_b[31];
                    state_reg    <= ST_DOT_ACC;
                end
                ST_DOT_ACC: begin
                    acc_reg <= acc_reg + term_c;
                    if (32'(i_reg) + 32'd1 < 32'(k_reg)) begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_DOT_RD;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (load_out) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            if (acc_reg > ACC_MAX) begin
                out_value_reg <= Q_MAX;
                out_sat_reg   <= 1'b1;
            end else if (acc_reg < ACC_MIN) begin
                out_value_reg <= Q_MIN;
                out_sat_reg   <= 1'b1;
            end else begin
                out_value_reg <= acc_reg[31:0];
                out_sat_reg   <= flag_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_sat   = out_sat_reg;

endmodule

@@ hw/rtl/bspline_de_boor_eval.sv @@
// ----------------------------------------------------------------------------
// bspline_de_boor_eval
// b-spline evaluator: knot/coefficient loading and de boor evaluation, q16.16
// ----------------------------------------------------------------------------
// flow: a table write is queued and then written to its table when the back end pops
//   it; an evaluate runs span search, recursion and dot product before its result
// throughput: one item at a time in the back end; each recursion update runs two
//   divisions on the shared divider (one quotient bit per cycle)
// reset: aresetn synchronous, active low; order and count return to 4, queue and
//   output register empty; knot and coefficient tables are not cleared
module bspline_de_boor_eval
    import bsde_pkg::*;
#(
    parameter int MAX_ORDER   = DEF_MAX_ORDER,
    parameter int MAX_CONTROL = DEF_MAX_CONTROL
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // table_index[10:0], entry_value[42:11],
                                        // abscissa[74:43], zero pad
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // spline_value[31:0]
    output logic [0:0]  m_axis_tuser,   // saturated[0]
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    bsde_item_t         in_item;
    bsde_item_t         q_item;
    logic               q_valid;
    logic               q_pop;
    logic [3:0]         spline_order_reg;
    logic [10:0]        control_count_reg;
    logic               cfg_wr;
    logic signed [31:0] out_value;
    logic               out_sat;

    // unpack the input transfer
    assign in_item.opcode      = s_axis_tuser;
    assign in_item.table_index = s_axis_tdata[10:0];
    assign in_item.entry_value = $signed(s_axis_tdata[42:11]);
    assign in_item.abscissa    = $signed(s_axis_tdata[74:43]);

    // register port: word address picks the register, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spline_order_reg  <= 4'd4;
            control_count_reg <= 11'd4;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_ORDER) begin
                spline_order_reg <= pwdata[3:0];
            end else begin
                control_count_reg <= pwdata[10:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_COUNT) ? {21'b0, control_count_reg}
                                            : {28'b0, spline_order_reg};

    // front end: classify and queue
    bsde_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // back end: tables, search, recursion, output register
    bsde_back #(
        .MAX_ORDER   (MAX_ORDER),
        .MAX_CONTROL (MAX_CONTROL)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .spline_order  (spline_order_reg),
        .control_count (control_count_reg),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_value     (out_value),
        .out_sat       (out_sat)
    );

    assign m_axis_tdata    = out_value;
    assign m_axis_tuser[0] = out_sat;

    // back end only pops an item the queue really holds
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // a stalled input side means the queue holds work
    a_stall_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> q_valid)
        else $error("input stalled with empty queue");

    // no result survives reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the de boor b-spline evaluator: loads knot and
// coefficient tables, evaluates at random abscissas under several order and
// count settings, and checks every result against a fixed-point predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import bsde_pkg::*;

    localparam int KNOT_DEPTH   = DEF_MAX_CONTROL + DEF_MAX_ORDER;
    localparam int STALL_LIMIT  = 40000;   // cycles with no transfer anywhere
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [31:0] value;
        bit          clipped;
    } spline_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: fixed-point b-spline predictor and queue of pending results
    // ------------------------------------------------------------------------
    class spline_scoreboard;
        longint         knots[KNOT_DEPTH];
        longint         coefs[DEF_MAX_CONTROL];
        logic [3:0]     order_reg;
        logic [10:0]    count_reg;
        spline_result_t pending_q[$];
        int             errors;
        int             checked;
        int             clipped_seen;

        function new();
            order_reg = 4;
            count_reg = 4;
        endfunction

        function int order_eff();
            int k;
            k = order_reg;
            if (k < 2) k = 2;
            if (k > DEF_MAX_ORDER) k = DEF_MAX_ORDER;
            return k;
        endfunction

        function int count_eff();
            int n;
            n = count_reg;
            if (n < order_eff()) n = order_eff();
            if (n > DEF_MAX_CONTROL) n = DEF_MAX_CONTROL;
            return n;
        endfunction

        function longint clip(longint v, ref bit f);
            if (v > longint'(Q_MAX)) begin
                f = 1;
                return longint'(Q_MAX);
            end
            if (v < longint'(Q_MIN)) begin
                f = 1;
                return longint'(Q_MIN);
            end
            return v;
        endfunction

        function longint unsigned mag(longint v);
            return v < 0 ? longint'(-v) : v;
        endfunction

        // a * b / d truncated toward zero, zero denominator gives zero
        function longint scaled_ratio(longint a, longint b, longint d, ref bit f);
            longint unsigned q;
            bit neg;
            if (d == 0) return 0;
            q = (mag(a) * mag(b)) / mag(d);
            neg = ((a < 0) != (b < 0)) != (d < 0);
            return clip(neg ? -longint'(q) : longint'(q), f);
        endfunction

        function spline_result_t spline_at(longint x);
            longint dl[DEF_MAX_ORDER], dr[DEF_MAX_ORDER], basis[DEF_MAX_ORDER];
            longint acc, carry, den, bi, c;
            longint unsigned p;
            int k, n, span, lo, hi, mid;
            bit f;
            spline_result_t r;
            k = order_eff();
            n = count_eff();
            f = 0;
            acc = 0;
            // span search, clamped to the edge spans outside the knot range
            if (x < knots[k-1]) begin
                span = k - 1;
            end else if (x >= knots[n]) begin
                span = n - 1;
            end else begin
                lo = k - 1;
                hi = n;
                while (hi - lo > 1) begin
                    mid = (lo + hi) / 2;
                    if (x < knots[mid]) hi = mid; else lo = mid;
                end
                span = lo;
            end
            // triangular basis recursion
            basis[0] = longint'(Q_ONE);
            for (int j = 0; j + 1 < k; j++) begin
                carry = 0;
                dr[j] = clip(knots[span+j+1] - x, f);
                dl[j] = clip(x - knots[span-j], f);
                for (int i = 0; i <= j; i++) begin
                    den = dr[i] + dl[j-i];
                    bi = basis[i];
                    basis[i] = clip(carry + scaled_ratio(dr[i], bi, den, f), f);
                    carry = scaled_ratio(dl[j-i], bi, den, f);
                end
                basis[j+1] = carry;
            end
            for (int i = 0; i < k; i++) begin
                c = coefs[span-(k-1)+i];
                p = (mag(basis[i]) * mag(c)) >> 16;
                acc += ((basis[i] < 0) != (c < 0)) ? -longint'(p) : longint'(p);
            end
            r.value = 32'(clip(acc, f));
            r.clipped = f;
            return r;
        endfunction

        function void note_item(logic [1:0] op, logic [10:0] idx,
                                logic signed [31:0] val, logic signed [31:0] x);
            if (op == OP_KNOT && idx < KNOT_DEPTH) knots[idx] = val;
            else if (op == OP_COEF && idx < DEF_MAX_CONTROL) coefs[idx] = val;
            else if (op == OP_EVAL) pending_q.push_back(spline_at(x));
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [31:0] value, logic clipped);
            spline_result_t e;
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", value));
                return;
            end
            e = pending_q.pop_front();
            checked++;
            if (clipped) clipped_seen++;
            if (value !== e.value)
                report_mismatch($sformatf("spline_value %h, expected %h", value, e.value));
            if (clipped !== e.clipped)
                report_mismatch($sformatf("saturated %b, expected %b", clipped, e.clipped));
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;     // table_index[10:0], entry_value[42:11],
                                        // abscissa[74:43], zero pad
    logic [1:0]  s_axis_tuser = '0;     // opcode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [31:0] m_axis_tdata;          // spline_value[31:0]
    logic [0:0]  m_axis_tuser;          // saturated[0]
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    spline_scoreboard sb;
    bit quiet = 0;          // when set neither side idles
    int stall_cycles = 0;
    int items_sent = 0;

    bspline_de_boor_eval u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // result side: check each transfer, then pick the next ready value
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser[0]);
            m_axis_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 10);
        end
    end

    // watchdog on cycles with no transfer on either stream
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog expired with %0d results pending", sb.pending_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // one input transfer, with an occasional gap before it
    task send_item(logic [1:0] op, logic [10:0] idx, logic [31:0] val, logic [31:0] x);
        if (!quiet && $urandom_range(0, 99) < 10) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {5'b0, x, val, idx};
        s_axis_tuser  <= op;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_item(op, idx, val, x);
        items_sent++;
    endtask

    // drain: hold the input, wait for every pending result, then let writes retire
    task drain();
        s_axis_tvalid <= 0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // register write: setup cycle then access cycle
    task reg_write(logic index, logic [31:0] value);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        if (index == REG_ORDER) sb.order_reg = value[3:0];
        else sb.count_reg = value[10:0];
    endtask

    function logic [31:0] random_coef();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
        if (r < 8) return $urandom;
        return r == 8 ? Q_MAX : Q_MIN;
    endfunction

    // sorted knot vector with random spacing and some repeats, plus coefficients
    task load_tables();
        int need;
        longint step_max, knot;
        need = sb.count_eff() + sb.order_eff();
        step_max = 64'd4000000000 / need;
        if ($urandom_range(0, 3) == 0 && step_max > (4 << 16)) step_max = 4 << 16;
        knot = -(step_max * need) / 2;
        for (int i = 0; i < need; i++) begin
            send_item(OP_KNOT, 11'(i), 32'(knot), $urandom);
            if ($urandom_range(0, 99) >= 15) knot += $urandom_range(1, 32'(step_max));
        end
        for (int i = 0; i < sb.count_eff(); i++)
            send_item(OP_COEF, 11'(i), random_coef(), $urandom);
    endtask

    // mostly evaluations inside the knot range, with noise and table rewrites
    task random_items(int evals);
        int r, need, got;
        longint lo, hi;
        logic [31:0] x;
        need = sb.count_eff() + sb.order_eff();
        got = 0;
        while (got < evals) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                send_item(OP_UNUSED, 11'($urandom), $urandom, $urandom);
            end else if (r < 9) begin
                if (r[0]) send_item(OP_KNOT, 11'($urandom_range(KNOT_DEPTH, 2047)),
                                    $urandom, $urandom);
                else send_item(OP_COEF, 11'($urandom_range(DEF_MAX_CONTROL, 2047)),
                               $urandom, $urandom);
            end else if (r < 14) begin
                send_item(OP_COEF, 11'($urandom_range(0, sb.count_eff() - 1)),
                          random_coef(), $urandom);
            end else if (r < 16) begin
                // disturbs the ordering of the knots
                send_item(OP_KNOT, 11'($urandom_range(0, need - 1)), $urandom, $urandom);
            end else begin
                lo = sb.knots[sb.order_eff() - 1];
                hi = sb.knots[sb.count_eff()];
                r = $urandom_range(0, 9);
                if (r < 7 && hi > lo) x = 32'(lo + longint'($urandom) % (hi - lo + 1));
                else if (r < 8) x = 32'(sb.knots[$urandom_range(0, need - 1)]);
                else x = $urandom;
                send_item(OP_EVAL, 11'($urandom), $urandom, x);
                got++;
            end
        end
    endtask

    initial begin
        int orders[10] = '{2, 3, 4, 10, 15, 1, 5, 6, 0, 8};
        int counts[10] = '{2, 8, 16, 10, 0, 40, 3, 30, 100, 12};
        int evals[10]  = '{50, 110, 150, 25, 10, 110, 70, 60, 40, 15};
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: clamped cubic with repeated end knots at reset settings
        for (int i = 0; i < 8; i++)
            send_item(OP_KNOT, 11'(i), i < 4 ? 32'd0 : Q_ONE, '0);
        send_item(OP_COEF, 11'd0, Q_MAX, '0);
        send_item(OP_COEF, 11'd1, Q_MIN, '0);
        send_item(OP_COEF, 11'd2, Q_ONE, '0);
        send_item(OP_COEF, 11'd3, 32'hfffe_0000, '0);
        // writes past the end of each table are dropped
        send_item(OP_KNOT, 11'h7ff, 32'hdead_beef, '0);
        send_item(OP_COEF, 11'd1024, 32'hdead_beef, '0);
        send_item(OP_UNUSED, 11'h7ff, Q_MAX, Q_MAX);
        send_item(OP_EVAL, '0, '0, Q_MIN);
        send_item(OP_EVAL, '0, '0, Q_MAX);
        send_item(OP_EVAL, '0, '0, '0);
        send_item(OP_EVAL, '0, '0, 32'h0000_8000);
        send_item(OP_EVAL, '0, '0, Q_ONE);
        send_item(OP_EVAL, 11'h7ff, 32'hffff_ffff, 32'hffff_ffff);
        send_item(OP_EVAL, '0, '0, 32'h0001_8000);

        // phases over order and count, out-of-range settings clamp in the block
        for (int p = 0; p < 10; p++) begin
            drain();
            quiet = (p == 2);
            reg_write(REG_ORDER, orders[p]);
            reg_write(REG_COUNT, counts[p]);
            load_tables();
            random_items(evals[p]);
        end
        quiet = 0;

        drain();
        repeat (200) @(posedge aclk);
        if (sb.pending_q.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending_q.size()));
        $display("covered %0d input transfers and %0d evaluations, %0d saturated,",
                 items_sent, sb.checked, sb.clipped_seen);
        $display("across orders 2 to 10 and counts 2 to 100 including clamped settings");
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
